FILE: rtl/isrp_pkg.sv
package isrp_pkg;

    localparam int SLOTS     = 1024;
    localparam int KEY_W     = 10;
    localparam int CNT_W     = 10;
    localparam int RW_W      = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int DIV_CNT_W = $clog2(RW_W);
    localparam int CAPACITY  = ((SLOTS - 1) < 1023) ? (SLOTS - 1) : 1023;

    typedef logic [KEY_W-1:0]     t_key;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [RW_W-1:0]      t_rword;
    typedef logic [DIV_CNT_W-1:0] t_div_cnt;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_REMOVE,
        OP_SEARCH,
        OP_PICK
    } t_op;

    typedef enum logic [2:0] {
        ST_OK,
        ST_PRESENT,
        ST_NOT_FOUND,
        ST_FULL,
        ST_EMPTY
    } t_status;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_SLOT,
        POS_NEW
    } t_pos_sel;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_MAP_CHK,
        S_REM_MOVE,
        S_REM_CLR,
        S_DIV,
        S_PICK_RD,
        S_PICK_CAP,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op    operation;
        t_key   key;
        t_rword random_word;
    } t_in;

    typedef struct packed {
        t_status status;
        t_cnt    position;
        t_key    picked_key;
        t_cnt    member_count;
    } t_out;

    typedef struct packed {
        logic     clr_wr;
        logic     load_in;
        logic     map_chk;
        logic     add_commit;
        logic     rem_move;
        logic     rem_clear;
        logic     div_init;
        logic     div_step;
        logic     store_rd_pick;
        logic     res_we;
        t_status  res_status;
        t_pos_sel res_pos;
        logic     res_pick;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic found;
        logic full;
        logic empty;
        logic clr_last;
        logic div_last;
        logic out_busy;
    } t_stat;

    localparam t_cnt   CAP_CNT  = t_cnt'(CAPACITY);
    localparam t_div_cnt DIV_LAST = t_div_cnt'(RW_W - 1);

endpackage

FILE: rtl/isrp_ram.sv
module isrp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/isrp_ctrl.sv
module isrp_ctrl import isrp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                if (i_stat.op == OP_PICK) begin
                    if (i_stat.empty) begin
                        o_cmd.res_we     = 1'b1;
                        o_cmd.res_status = ST_EMPTY;
                        o_cmd.res_pos    = POS_ZERO;
                        n_state          = S_DONE;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_state        = S_DIV;
                    end
                end else begin
                    n_state = S_MAP_CHK;
                end
            end
            S_MAP_CHK: begin
                o_cmd.map_chk = 1'b1;
                n_state       = S_DONE;
                case (i_stat.op)
                    OP_ADD: begin
                        o_cmd.res_we = 1'b1;
                        if (i_stat.found) begin
                            o_cmd.res_status = ST_PRESENT;
                            o_cmd.res_pos    = POS_SLOT;
                        end else if (i_stat.full) begin
                            o_cmd.res_status = ST_FULL;
                            o_cmd.res_pos    = POS_ZERO;
                        end else begin
                            o_cmd.add_commit = 1'b1;
                            o_cmd.res_status = ST_OK;
                            o_cmd.res_pos    = POS_NEW;
                        end
                    end
                    OP_SEARCH: begin
                        o_cmd.res_we = 1'b1;
                        if (i_stat.found) begin
                            o_cmd.res_status = ST_OK;
                            o_cmd.res_pos    = POS_SLOT;
                        end else begin
                            o_cmd.res_status = ST_NOT_FOUND;
                            o_cmd.res_pos    = POS_ZERO;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.found) begin
                            n_state = S_REM_MOVE;
                        end else begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = ST_NOT_FOUND;
                            o_cmd.res_pos    = POS_ZERO;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_REM_MOVE: begin
                o_cmd.rem_move = 1'b1;
                n_state        = S_REM_CLR;
            end
            S_REM_CLR: begin
                o_cmd.rem_clear  = 1'b1;
                o_cmd.res_we     = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_pos    = POS_ZERO;
                n_state          = S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_PICK_RD;
                end
            end
            S_PICK_RD: begin
                o_cmd.store_rd_pick = 1'b1;
                n_state             = S_PICK_CAP;
            end
            S_PICK_CAP: begin
                o_cmd.res_we     = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_pos    = POS_ZERO;
                o_cmd.res_pick   = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/isrp_dp.sv
module isrp_dp import isrp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_data,
    output t_out  o_data,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_cmd  i_cmd,
    output t_stat o_stat
);

    t_op      r_op;
    t_key     r_key;
    t_rword   r_rw;
    t_cnt     r_count;
    t_cnt     r_slot;
    t_key     r_clr_addr;
    t_cnt     r_rem;
    t_rword   r_div_word;
    t_div_cnt r_div_cnt;
    t_status  r_res_status;
    t_cnt     r_res_pos;
    t_key     r_res_pick;
    t_out     r_out;
    logic     r_out_valid;

    t_cnt          w_map_rdata;
    t_key          w_store_rdata;
    logic          w_map_we;
    t_key          w_map_waddr;
    t_cnt          w_map_wdata;
    logic          w_store_we;
    t_slot         w_store_waddr;
    t_key          w_store_wdata;
    t_slot         w_store_raddr;
    t_cnt          w_count_inc;
    logic [CNT_W:0] w_trial;
    logic           w_ge;

    assign w_count_inc = t_cnt'(r_count + 1'b1);

    isrp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (2 ** KEY_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_map_waddr),
        .i_wdata (w_map_wdata),
        .i_raddr (r_key),
        .o_rdata (w_map_rdata)
    );

    isrp_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store_we),
        .i_waddr (w_store_waddr),
        .i_wdata (w_store_wdata),
        .i_raddr (w_store_raddr),
        .o_rdata (w_store_rdata)
    );

    always_comb begin
        w_map_we    = 1'b0;
        w_map_waddr = r_key;
        w_map_wdata = '0;
        if (i_cmd.clr_wr) begin
            w_map_we    = 1'b1;
            w_map_waddr = r_clr_addr;
        end else if (i_cmd.add_commit) begin
            w_map_we    = 1'b1;
            w_map_wdata = w_count_inc;
        end else if (i_cmd.rem_move) begin
            w_map_we    = 1'b1;
            w_map_waddr = w_store_rdata;
            w_map_wdata = r_slot;
        end else if (i_cmd.rem_clear) begin
            w_map_we    = 1'b1;
        end
    end

    always_comb begin
        w_store_we    = 1'b0;
        w_store_waddr = t_slot'(w_count_inc);
        w_store_wdata = r_key;
        if (i_cmd.add_commit) begin
            w_store_we = 1'b1;
        end else if (i_cmd.rem_move) begin
            w_store_we    = 1'b1;
            w_store_waddr = t_slot'(r_slot);
            w_store_wdata = w_store_rdata;
        end
    end

    assign w_store_raddr = i_cmd.store_rd_pick ? t_slot'(t_cnt'(r_rem + 1'b1))
                                               : t_slot'(r_count);

    // restoring remainder, one dividend bit per step
    assign w_trial = {r_rem, r_div_word[RW_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= t_key'(r_clr_addr + 1'b1);
            end
            if (i_cmd.add_commit) begin
                r_count <= w_count_inc;
            end else if (i_cmd.rem_clear) begin
                r_count <= t_cnt'(r_count - 1'b1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_data.operation;
            r_key <= i_data.key;
            r_rw  <= i_data.random_word;
        end
        if (i_cmd.map_chk) begin
            r_slot <= w_map_rdata;
        end
        if (i_cmd.div_init) begin
            r_rem      <= '0;
            r_div_word <= r_rw;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem      <= w_ge ? t_cnt'(w_trial - {1'b0, r_count}) : t_cnt'(w_trial);
            r_div_word <= {r_div_word[RW_W-2:0], 1'b0};
            r_div_cnt  <= t_div_cnt'(r_div_cnt + 1'b1);
        end
        if (i_cmd.res_we) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_pos)
                POS_SLOT: r_res_pos <= w_map_rdata;
                POS_NEW:  r_res_pos <= w_count_inc;
                default:  r_res_pos <= '0;
            endcase
            r_res_pick <= i_cmd.res_pick ? w_store_rdata : '0;
        end
        if (i_cmd.out_load) begin
            r_out.status       <= r_res_status;
            r_out.position     <= r_res_pos;
            r_out.picked_key   <= r_res_pick;
            r_out.member_count <= r_count;
        end
    end

    assign o_data = r_out;
    assign o_valid = r_out_valid;

    assign o_stat.op       = r_op;
    assign o_stat.found    = (w_map_rdata != '0) && (w_map_rdata <= r_count);
    assign o_stat.full     = (r_count >= CAP_CNT);
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.clr_last = (r_clr_addr == '1);
    assign o_stat.div_last = (r_div_cnt == DIV_LAST);
    assign o_stat.out_busy = r_out_valid && !i_ready;

endmodule

FILE: rtl/indexed_set_with_random_pick_core.sv
// before a result: add and search check the map; remove also moves the last member
// in and clears the key; pick runs 16 bit-serial remainder steps and a store read
// one transfer is taken at a time; a finished result waits in the output register
// while the next transfer is taken
// reset: synchronous, active low; count cleared, then each position map entry is
// swept to zero with the input ready low
module indexed_set_with_random_pick_core import isrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    isrp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    isrp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .o_data  (o_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule

FILE: test/isrp_set_checker.sv
module isrp_set_checker import isrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_in  i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_out i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_peak_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEYS = 2 ** KEY_W;

    t_cnt slot_map [KEYS];
    t_key members [SLOTS];
    t_cnt n_members;
    t_out want_q [$];
    int   fail_total;
    int   checked_total;
    int   peak;

    // updates the shadow set and returns the result the block must give
    function automatic t_out apply_set_op(input t_in req);
        t_out res;
        t_cnt slot;
        t_key moved;
        res = '0;
        res.status = ST_OK;
        slot = slot_map[req.key];
        if (slot > n_members) begin
            slot = '0;
        end
        case (req.operation)
            OP_ADD: begin
                if (slot != '0) begin
                    res.status = ST_PRESENT;
                    res.position = slot;
                end else if (n_members >= CAP_CNT) begin
                    res.status = ST_FULL;
                end else begin
                    n_members = n_members + 1'b1;
                    members[n_members] = req.key;
                    slot_map[req.key] = n_members;
                    res.position = n_members;
                end
            end
            OP_REMOVE: begin
                if (slot == '0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    // last member fills the hole
                    moved = members[n_members];
                    members[slot] = moved;
                    n_members = n_members - 1'b1;
                    slot_map[moved] = slot;
                    slot_map[req.key] = '0;
                end
            end
            OP_SEARCH: begin
                if (slot == '0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.position = slot;
                end
            end
            default: begin
                if (n_members == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.picked_key = members[int'(req.random_word) % int'(n_members) + 1];
                end
            end
        endcase
        res.member_count = n_members;
        return res;
    endfunction

    task automatic report_field(input string field, input int want, input logic [9:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < KEYS; k++) begin
                slot_map[k] = '0;
            end
            n_members = '0;
            want_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                checked_total++;
                if (want_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, actual %p", $time, i_rsp);
                end else begin
                    want = want_q.pop_front();
                    if (i_rsp !== want) begin
                        fail_total++;
                        if (i_rsp.status !== want.status) begin
                            report_field("status", want.status, 10'(i_rsp.status));
                        end
                        if (i_rsp.position !== want.position) begin
                            report_field("position", want.position, i_rsp.position);
                        end
                        if (i_rsp.picked_key !== want.picked_key) begin
                            report_field("picked_key", want.picked_key, i_rsp.picked_key);
                        end
                        if (i_rsp.member_count !== want.member_count) begin
                            report_field("member_count", want.member_count,
                                         i_rsp.member_count);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                want_q.push_back(apply_set_op(i_req));
                if (int'(n_members) > peak) begin
                    peak = n_members;
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= want_q.size();
        o_checked    <= checked_total;
        o_peak_count <= peak;
    end

endmodule

FILE: test/indexed_set_with_random_pick_core_tb.sv
module indexed_set_with_random_pick_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isrp_pkg::*;

    localparam int KEYS        = 2 ** KEY_W;
    localparam int CYCLE_LIMIT = 600000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data  = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    int   fail_count;
    int   pending;
    int   checked;
    int   peak_count;
    int   tx_idle_pct = 38;
    int   rx_idle_pct = 62;
    int   cycles;
    int   op_total [4];
    t_key key_pool [16];

    indexed_set_with_random_pick_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    isrp_set_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req        (i_data),
        .i_rsp_valid  (o_valid),
        .i_rsp_ready  (i_ready),
        .i_rsp        (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_peak_count (peak_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_req(input t_op op, input t_key key, input t_rword rw);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{operation: op, key: key, random_word: rw};
        do @(posedge i_clk); while (!o_ready);
        op_total[op]++;
    endtask

    // hold off until every outstanding result has been returned
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic run_mixed(input int n);
        t_op  op;
        t_key key;
        int   r;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            op = (r < 35) ? OP_ADD : (r < 60) ? OP_REMOVE : (r < 80) ? OP_SEARCH : OP_PICK;
            key = ($urandom_range(0, 7) == 0) ? t_key'($urandom)
                                              : key_pool[$urandom_range(0, 15)];
            send_req(op, key, t_rword'($urandom));
        end
    endtask

    // every key added in shuffled order, so the store fills and then overflows
    task automatic fill_store();
        int order [KEYS];
        int j;
        int tmp;
        for (int k = 0; k < KEYS; k++) begin
            order[k] = k;
        end
        for (int k = KEYS - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < KEYS; k++) begin
            send_req(OP_ADD, t_key'(order[k]), t_rword'($urandom));
            if (k % 64 == 63) begin
                send_req(OP_PICK, t_key'($urandom), t_rword'($urandom));
            end
        end
        send_req(OP_ADD, t_key'(order[KEYS-1]), '1);
        send_req(OP_ADD, t_key'(order[0]), '0);
        send_req(OP_SEARCH, t_key'(order[KEYS-1]), '0);
        send_req(OP_PICK, '0, '1);
        send_req(OP_PICK, '1, '0);
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < 16; k++) begin
            key_pool[k] = t_key'($urandom);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty set, duplicates, removal of first and last member
        send_req(OP_PICK,   '0,        16'hffff);
        send_req(OP_SEARCH, '0,        '0);
        send_req(OP_REMOVE, '1,        '0);
        send_req(OP_ADD,    '0,        '0);
        send_req(OP_ADD,    '1,        '1);
        send_req(OP_ADD,    '0,        16'h1234);
        send_req(OP_SEARCH, '1,        '0);
        send_req(OP_PICK,   '0,        16'h0000);
        send_req(OP_PICK,   '1,        16'hffff);
        send_req(OP_ADD,    10'h2aa,   16'haaaa);
        send_req(OP_ADD,    10'h155,   16'h5555);
        send_req(OP_PICK,   10'h2aa,   16'h5555);
        send_req(OP_REMOVE, '0,        '0);
        send_req(OP_SEARCH, 10'h155,   '0);
        send_req(OP_SEARCH, '0,        '0);
        send_req(OP_REMOVE, '0,        '0);
        send_req(OP_REMOVE, 10'h155,   '0);
        send_req(OP_REMOVE, '1,        '0);
        send_req(OP_REMOVE, 10'h2aa,   '0);
        send_req(OP_PICK,   '0,        '0);
        send_req(OP_SEARCH, 10'h2aa,   '1);
        send_req(OP_ADD,    10'h001,   16'hffff);
        drain_results();

        run_mixed(35);
        drain_results();

        tx_idle_pct = 62;
        rx_idle_pct = 38;
        run_mixed(35);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_store();
        run_mixed(13);
        drain_results();

        repeat (40) @(posedge i_clk);
        $display("covered %0d requests: %0d add, %0d remove, %0d search, %0d pick",
                 op_total[0] + op_total[1] + op_total[2] + op_total[3],
                 op_total[OP_ADD], op_total[OP_REMOVE], op_total[OP_SEARCH], op_total[OP_PICK]);
        $display("%0d results compared, member count peaked at %0d", checked, peak_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
